// File: rtl/i4mv_pkg.sv
// Shared types and constants for the int4 weight matrix-vector row dot block.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package i4mv_pkg;

    localparam int IDX_W       = 12;
    localparam int ACT_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int PROD_W      = ACT_W + NIB_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int ACC_W       = 24;
    localparam int ROW_W       = 16;
    localparam int POS_W       = 11;
    localparam int PC_W        = 12;
    localparam int CFG_W       = 16;
    localparam int INDEX_SPACE = 1 << IDX_W;

    localparam logic [PC_W-1:0] MAX_PAIRS = PC_W'(2048);

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_WEIGHT = 1'b1;

    localparam logic CFG_PAIR_COUNT = 1'b0;
    localparam logic CFG_ROW_COUNT  = 1'b1;

    typedef enum logic
    {
        OUT_EMPTY,
        OUT_FULL
    } out_state_t;

    typedef struct packed
    {
        logic             wr_en;
        logic             rd_en;
        logic [POS_W-1:0] rd_pos;
        logic             adv;
        logic             acc_en;
        logic             row_end;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/i4mv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module i4mv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/i4mv_ctrl.sv
// Controller: config registers, byte and row counters, pipeline valids, output state.
// Depends on i4mv_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module i4mv_ctrl
    import i4mv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             in_valid,
    input  wire logic             req_type,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [ROW_W-1:0] row_index,
    output logic                  last_row,
    output dp_cmd_t               cmd
);

    out_state_t       state_reg, state_next;
    logic [PC_W-1:0]  pair_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [ROW_W-1:0] row_ctr_reg, row_ctr_next;
    logic             s1_valid_reg, s1_end_reg, s1_last_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s2_valid_reg, s2_end_reg, s2_last_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [ROW_W-1:0] row_index_reg;
    logic             last_row_reg;

    logic             freeze, adv, in_acc, wt_acc, ld_acc, out_load, out_take;
    logic [PC_W-1:0]  eff_pairs, pos_inc;
    logic [ROW_W-1:0] eff_rows;
    logic             byte_end, row_last;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg <= PC_W'(128);
            row_count_reg  <= ROW_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAIR_COUNT: pair_count_reg <= cfg_data[PC_W-1:0];
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data[ROW_W-1:0];
            endcase
        end
    end

    // row bookkeeping at acceptance
    always_comb
    begin
        if (pair_count_reg == '0)
            eff_pairs = PC_W'(1);
        else if (pair_count_reg > MAX_PAIRS)
            eff_pairs = MAX_PAIRS;
        else
            eff_pairs = pair_count_reg;
        eff_rows = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
        pos_inc  = {1'b0, pos_reg} + PC_W'(1);
        byte_end = (pos_inc >= eff_pairs);
        row_last = (({1'b0, row_ctr_reg} + (ROW_W+1)'(1)) >= {1'b0, eff_rows});
    end

    assign in_acc = in_valid && !in_stall;
    assign wt_acc = in_acc && (req_type == REQ_WEIGHT);
    assign ld_acc = in_acc && (req_type == REQ_LOAD);
    assign adv    = !freeze;

    always_comb
    begin
        pos_next     = pos_reg;
        row_ctr_next = row_ctr_reg;
        if (wt_acc)
        begin
            pos_next = byte_end ? '0 : pos_inc[POS_W-1:0];
            if (byte_end)
                row_ctr_next = row_last ? '0 : row_ctr_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            row_ctr_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            row_ctr_reg <= row_ctr_next;
            if (adv)
            begin
                s1_valid_reg <= wt_acc;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_end_reg  <= byte_end;
            s1_last_reg <= row_last;
            s1_row_reg  <= row_ctr_reg;
            s2_end_reg  <= s1_end_reg;
            s2_last_reg <= s1_last_reg;
            s2_row_reg  <= s1_row_reg;
        end
        if (out_load)
        begin
            row_index_reg <= s2_row_reg;
            last_row_reg  <= s2_last_reg;
        end
    end

    // output holding state
    assign out_take = (state_reg == OUT_FULL) && !out_stall;
    assign out_load = adv && s2_valid_reg && s2_end_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            OUT_EMPTY:
            begin
                if (out_load)
                    state_next = OUT_FULL;
            end
            OUT_FULL:
            begin
                if (!out_load && out_take)
                    state_next = OUT_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= OUT_EMPTY;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        out_valid = 1'b0;
        freeze    = 1'b0;
        unique case (state_reg)
            OUT_EMPTY:
            begin
                out_valid = 1'b0;
                freeze    = 1'b0;
            end
            OUT_FULL:
            begin
                out_valid = 1'b1;
                freeze    = s2_valid_reg && s2_end_reg && out_stall;
            end
        endcase
    end

    assign in_stall  = freeze;
    assign row_index = row_index_reg;
    assign last_row  = last_row_reg;

    always_comb
    begin
        cmd.wr_en   = ld_acc;
        cmd.rd_en   = wt_acc;
        cmd.rd_pos  = pos_reg;
        cmd.adv     = adv;
        cmd.acc_en  = adv && s2_valid_reg;
        cmd.row_end = s2_end_reg;
    end

endmodule

`default_nettype wire

// File: rtl/i4mv_dpath.sv
// Datapath: even/odd activation banks, nibble products, row accumulator, sum register.
// Depends on i4mv_pkg and i4mv_ram; commanded by i4mv_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module i4mv_dpath
    import i4mv_pkg::*;
#(
    parameter int MAX_VECTOR_LEN = 4096
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dp_cmd_t                 cmd,
    input  wire logic        [IDX_W-1:0] act_index,
    input  wire logic signed [ACT_W-1:0] act_value,
    input  wire logic       [BYTE_W-1:0] weight_byte,
    output logic signed      [ACC_W-1:0] dot_value
);

    localparam int STORE_LEN  = (MAX_VECTOR_LEN < INDEX_SPACE) ? MAX_VECTOR_LEN : INDEX_SPACE;
    localparam int EVEN_DEPTH = (STORE_LEN + 1) / 2;
    localparam int ODD_DEPTH  = STORE_LEN / 2;
    localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
    localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
    localparam logic [IDX_W:0] STORE_END = (IDX_W+1)'(STORE_LEN);

    logic              ld_ok, even_ok, odd_ok;
    logic [ACT_W-1:0]  even_rdata, odd_rdata;
    logic [IDX_W:0]    even_idx, odd_idx;

    logic              even_ok_reg, odd_ok_reg;
    logic [BYTE_W-1:0] wbyte_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] dot_reg;

    logic signed [ACT_W-1:0]  act_e, act_o;
    logic signed [NIB_W-1:0]  w_e, w_o;
    logic signed [PROD_W-1:0] p_e, p_o;
    logic signed [SUM_W-1:0]  prod_sum;
    logic signed [ACC_W-1:0]  acc_sum;

    assign ld_ok    = ({1'b0, act_index} < STORE_END);
    assign even_idx = {1'b0, cmd.rd_pos, 1'b0};
    assign odd_idx  = {1'b0, cmd.rd_pos, 1'b1};
    assign even_ok  = (even_idx < STORE_END);
    assign odd_ok   = (odd_idx < STORE_END);

    i4mv_ram #(
        .WIDTH (ACT_W),
        .DEPTH (EVEN_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (cmd.wr_en && ld_ok && !act_index[0]),
        .waddr (act_index[EVEN_AW:1]),
        .wdata (act_value),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_pos[EVEN_AW-1:0]),
        .rdata (even_rdata)
    );

    i4mv_ram #(
        .WIDTH (ACT_W),
        .DEPTH (ODD_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (cmd.wr_en && ld_ok && act_index[0]),
        .waddr (act_index[ODD_AW:1]),
        .wdata (act_value),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_pos[ODD_AW-1:0]),
        .rdata (odd_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.adv)
        begin
            even_ok_reg <= even_ok;
            odd_ok_reg  <= odd_ok;
            wbyte_reg   <= weight_byte;
            prod_reg    <= prod_sum;
        end
    end

    // nibble minus 8 is the nibble with its top bit flipped, read as signed
    always_comb
    begin
        act_e    = even_ok_reg ? $signed(even_rdata) : '0;
        act_o    = odd_ok_reg ? $signed(odd_rdata) : '0;
        w_e      = $signed({~wbyte_reg[NIB_W-1], wbyte_reg[NIB_W-2:0]});
        w_o      = $signed({~wbyte_reg[BYTE_W-1], wbyte_reg[BYTE_W-2:NIB_W]});
        p_e      = PROD_W'(act_e) * PROD_W'(w_e);
        p_o      = PROD_W'(act_o) * PROD_W'(w_o);
        prod_sum = SUM_W'(p_e) + SUM_W'(p_o);
    end

    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_en)
            acc_next = cmd.row_end ? '0 : acc_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en && cmd.row_end)
            dot_reg <= acc_sum;
    end

    assign dot_value = dot_reg;

endmodule

`default_nettype wire

// File: rtl/int4_weight_matvec_row_dot.sv
// Top level of the int4 weight by int8 activation row dot product block.
// Depends on i4mv_pkg, i4mv_ctrl, i4mv_dpath and i4mv_ram.
//
// Load items write one signed activation into a store of two RAM banks (even and odd
// positions, one read port each); weight items carry one packed byte whose two nibbles
// (minus 8) multiply activations 2p and 2p+1. One item is taken every unstalled cycle:
// each weight byte uses a single read of each bank, so a byte stream runs at one byte
// per clock. The row sum goes via the bank read, weight byte and product registers to
// an output register; input stalls only while that register is held and the next row's
// sum is ready to enter it. Loads past MAX_VECTOR_LEN are dropped and read as zero.
`timescale 1ns / 1ps
`default_nettype none

module int4_weight_matvec_row_dot
    import i4mv_pkg::*;
#(
    parameter int MAX_VECTOR_LEN = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic         [CFG_W-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     req_type,
    input  wire logic         [IDX_W-1:0] act_index,
    input  wire logic signed  [ACT_W-1:0] act_value,
    input  wire logic        [BYTE_W-1:0] weight_byte,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed       [ACC_W-1:0] dot_value,
    output logic              [ROW_W-1:0] row_index,
    output logic                          last_row
);

    dp_cmd_t cmd;

    i4mv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_index (row_index),
        .last_row  (last_row),
        .cmd       (cmd)
    );

    i4mv_dpath #(
        .MAX_VECTOR_LEN (MAX_VECTOR_LEN)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .act_index   (act_index),
        .act_value   (act_value),
        .weight_byte (weight_byte),
        .dot_value   (dot_value)
    );

endmodule

`default_nettype wire

// File: rtl/i4mv_checker.sv
// Port-level checks for int4_weight_matvec_row_dot, attached with a bind.
// Depends on i4mv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i4mv_checker
    import i4mv_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_stall,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic signed [ACC_W-1:0] dot_value,
    input wire logic        [ROW_W-1:0] row_index,
    input wire logic                    last_row
);

    // input only backs up behind a held row sum
    a_stall_needs_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled result");

    // no result right out of reset
    a_no_result_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("out_valid high right after reset");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(dot_value) && $stable(row_index) && $stable(last_row)))
        else $error("result item changed while stalled");

endmodule

bind int4_weight_matvec_row_dot i4mv_checker u_i4mv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dot_value (dot_value),
    .row_index (row_index),
    .last_row  (last_row)
);

`default_nettype wire

// File: dv/i4mv_dot_check.sv
// Row dot product checker: follows the config port, the input and the output
// channel, predicts each row sum and compares it field by field.
// Depends on i4mv_pkg for widths and codes.
`timescale 1ns / 1ps

module i4mv_dot_check
    import i4mv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic        [CFG_W-1:0] cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    req_type,
    input  logic        [IDX_W-1:0] act_index,
    input  logic signed [ACT_W-1:0] act_value,
    input  logic       [BYTE_W-1:0] weight_byte,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [ACC_W-1:0] dot_value,
    input  logic        [ROW_W-1:0] row_index,
    input  logic                    last_row,
    output int                      fail_count,
    output int                      pending
);

    localparam logic [PC_W-1:0]  PAIRS_AT_RESET = PC_W'(128);
    localparam logic [ROW_W-1:0] ROWS_AT_RESET  = ROW_W'(1);
    localparam int               WEIGHT_OFFSET  = 8;

    typedef struct packed
    {
        logic signed [ACC_W-1:0] sum;
        logic        [ROW_W-1:0] row;
        logic                    last;
    } row_sum_t;

    logic signed [ACT_W-1:0] act_mem [INDEX_SPACE];
    logic        [PC_W-1:0]  pair_reg;
    logic        [ROW_W-1:0] row_reg;
    logic signed [ACC_W-1:0] run_sum;
    logic        [POS_W-1:0] byte_pos;
    logic        [ROW_W-1:0] row_ctr;
    row_sum_t                row_sums_due [$];

    // both nibble products of one weight byte against its activation pair
    function automatic int byte_term(logic [POS_W-1:0] p, logic [BYTE_W-1:0] wb);
        int base;
        base = 2 * int'(p);
        return int'(act_mem[base]) * (int'(wb[NIB_W-1:0]) - WEIGHT_OFFSET)
             + int'(act_mem[base + 1]) * (int'(wb[BYTE_W-1:NIB_W]) - WEIGHT_OFFSET);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        row_sum_t want;
        int       span;
        int       rows;
        if (!rst_n)
        begin
            pair_reg   = PAIRS_AT_RESET;
            row_reg    = ROWS_AT_RESET;
            run_sum    = '0;
            byte_pos   = '0;
            row_ctr    = '0;
            fail_count = 0;
            row_sums_due.delete();
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (row_sums_due.size() == 0)
                begin
                    $error("row sum %0d for row %0d with none outstanding", dot_value, row_index);
                    fail_count++;
                end
                else
                begin
                    want = row_sums_due.pop_front();
                    if (dot_value !== want.sum)
                    begin
                        $error("dot_value: expected %0d, actual %0d", want.sum, dot_value);
                        fail_count++;
                    end
                    if (row_index !== want.row)
                    begin
                        $error("row_index: expected %0d, actual %0d", want.row, row_index);
                        fail_count++;
                    end
                    if (last_row !== want.last)
                    begin
                        $error("last_row: expected %0d, actual %0d", want.last, last_row);
                        fail_count++;
                    end
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == CFG_PAIR_COUNT)
                    pair_reg = cfg_data[PC_W-1:0];
                else
                    row_reg = cfg_data[ROW_W-1:0];
            end

            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_LOAD)
                    act_mem[act_index] = act_value;
                else
                begin
                    run_sum = run_sum + ACC_W'(byte_term(byte_pos, weight_byte));
                    span = (pair_reg == 0) ? 1 :
                           (pair_reg > MAX_PAIRS) ? int'(MAX_PAIRS) : int'(pair_reg);
                    if (int'(byte_pos) + 1 < span)
                        byte_pos = byte_pos + 1'b1;
                    else
                    begin
                        rows      = (row_reg == 0) ? 1 : int'(row_reg);
                        want.sum  = run_sum;
                        want.row  = row_ctr;
                        want.last = (int'(row_ctr) + 1 >= rows);
                        row_sums_due.push_back(want);
                        run_sum   = '0;
                        byte_pos  = '0;
                        row_ctr   = want.last ? '0 : row_ctr + 1'b1;
                    end
                end
            end
            pending = row_sums_due.size();
        end
    end

endmodule

// File: dv/int4_weight_matvec_row_dot_tb.sv
// Testbench top for int4_weight_matvec_row_dot: clock, reset, config writes,
// directed and random item streams with random stalls, and the final verdict.
// Depends on i4mv_pkg, the block and i4mv_dot_check.
`timescale 1ns / 1ps

module int4_weight_matvec_row_dot_tb;
    import i4mv_pkg::*;

    localparam int              DRAIN_CYCLES   = 8;
    localparam int              LONG_HOLD      = 300;
    localparam int              CYCLE_LIMIT    = 5_000_000;
    localparam int              RANDOM_ITEMS   = 1000;
    localparam logic [PC_W-1:0] PAIRS_AT_RESET = PC_W'(128);

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic                    cfg_index;
    logic        [CFG_W-1:0] cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    req_type;
    logic        [IDX_W-1:0] act_index;
    logic signed [ACT_W-1:0] act_value;
    logic       [BYTE_W-1:0] weight_byte;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [ACC_W-1:0] dot_value;
    logic        [ROW_W-1:0] row_index;
    logic                    last_row;
    int                      fail_count;
    int                      pending;

    bit                      act_known [INDEX_SPACE];
    logic        [PC_W-1:0]  pair_shadow;
    int                      row_pos;
    int                      items_sent;
    int                      send_calm;
    int                      cycle_count;
    bit                      hold_long;
    bit                      hold_active;

    int4_weight_matvec_row_dot dut (.*);

    i4mv_dot_check dot_check (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic int span_of(logic [PC_W-1:0] pc);
        if (pc == 0)
            return 1;
        if (pc > MAX_PAIRS)
            return int'(MAX_PAIRS);
        return int'(pc);
    endfunction

    task automatic send_item(logic req, logic [IDX_W-1:0] idx, logic [ACT_W-1:0] val,
                             logic [BYTE_W-1:0] wb);
        int gap;
        if (send_calm > 0)
        begin
            gap = 0;
            send_calm--;
        end
        else
        begin
            gap = gap_len();
            if ($urandom_range(0, 49) == 0)
                send_calm = $urandom_range(20, 80);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        act_index   <= idx;
        act_value   <= val;
        weight_byte <= wb;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic load_act(logic [IDX_W-1:0] idx, logic [ACT_W-1:0] val);
        send_item(REQ_LOAD, idx, val, BYTE_W'($urandom));
        act_known[idx] = 1'b1;
    endtask

    // one weight item; its activation pair is loaded first when not yet known
    task automatic push_byte(logic [BYTE_W-1:0] wb, bit noisy);
        int span;
        span = span_of(pair_shadow);
        if (noisy && $urandom_range(0, 5) == 0)
            load_act($urandom_range(0, 1) ? IDX_W'($urandom)
                                          : IDX_W'($urandom_range(0, 2 * span - 1)),
                     ACT_W'($urandom));
        for (int k = 0; k < 2; k++)
            if (!act_known[2 * row_pos + k] || (noisy && $urandom_range(0, 7) == 0))
                load_act(IDX_W'(2 * row_pos + k), ACT_W'($urandom));
        send_item(REQ_WEIGHT, IDX_W'($urandom), ACT_W'($urandom), wb);
        row_pos = (row_pos + 1 < span) ? row_pos + 1 : 0;
    endtask

    task automatic set_regs(bit set_pairs, logic [CFG_W-1:0] pairs, bit set_rows,
                            logic [CFG_W-1:0] rows);
        if (set_pairs)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_PAIR_COUNT;
            cfg_data  <= pairs;
            @(negedge clk);
            pair_shadow = pairs[PC_W-1:0];
        end
        if (set_rows)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_ROW_COUNT;
            cfg_data  <= rows;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // output stall pattern, with one long hold on request
    initial
    begin
        int len;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_long)
            begin
                hold_long   = 1'b0;
                hold_active = 1'b1;
                out_stall  <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_active = 1'b0;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(negedge clk);
            end
            else
            begin
                len = gap_len();
                out_stall <= (len != 0);
                repeat ((len != 0) ? len : $urandom_range(1, 4)) @(negedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int               start;
        int               pick;
        int               span;
        bit               set_p;
        bit               set_r;
        logic [CFG_W-1:0] pairs_word;
        logic [CFG_W-1:0] rows_word;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_PAIR_COUNT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        req_type    = REQ_LOAD;
        act_index   = '0;
        act_value   = '0;
        weight_byte = '0;
        pair_shadow = PAIRS_AT_RESET;
        row_pos     = 0;
        items_sent  = 0;
        send_calm   = 0;
        hold_long   = 1'b0;
        hold_active = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // activation extremes, including -128 against weight -8
        load_act(IDX_W'(0), 8'sd127);
        load_act(IDX_W'(1), -8'sd128);
        load_act(IDX_W'(2), -8'sd1);
        load_act(IDX_W'(3), 8'sd0);
        load_act(IDX_W'(4), -8'sd128);
        load_act(IDX_W'(5), -8'sd128);
        load_act(IDX_W'(6), 8'sd127);
        load_act(IDX_W'(7), 8'sd127);
        load_act(IDX_W'(4095), -8'sd128);
        load_act(IDX_W'(4094), 8'sd1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);

        // pair count lowered in the middle of a row
        quiesce();
        set_regs(1'b1, CFG_W'(2), 1'b0, '0);
        push_byte(8'h7F, 1'b0);

        // zero pair count and zero row count
        quiesce();
        set_regs(1'b1, CFG_W'(0), 1'b1, CFG_W'(0));
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);

        // row index wrap, then row count dropped to the counter's value
        quiesce();
        set_regs(1'b1, CFG_W'(1), 1'b1, CFG_W'(3));
        repeat (4) push_byte(BYTE_W'($urandom), 1'b0);
        quiesce();
        set_regs(1'b0, '0, 1'b1, CFG_W'(1));
        push_byte(BYTE_W'($urandom), 1'b0);

        // long output hold while the input keeps coming
        quiesce();
        set_regs(1'b0, '0, 1'b1, CFG_W'(5));
        hold_long = 1'b1;
        wait (hold_active);
        @(negedge clk);
        send_calm = 40;
        repeat (30) push_byte(BYTE_W'($urandom), 1'b1);

        // widest rows: pair count above the maximum, then at it
        quiesce();
        set_regs(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
        repeat (2048) push_byte(BYTE_W'($urandom), 1'b1);
        quiesce();
        set_regs(1'b1, CFG_W'(2048), 1'b0, '0);
        repeat (2048) push_byte(BYTE_W'($urandom), 1'b1);

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            quiesce();
            pick = $urandom_range(0, 99);
            pairs_word = CFG_W'($urandom);
            pairs_word[PC_W-1:0] = (pick < 70) ? PC_W'($urandom_range(1, 8)) :
                                   (pick < 95) ? PC_W'($urandom_range(9, 40)) : PC_W'(0);
            pick = $urandom_range(0, 99);
            rows_word = (pick < 40) ? CFG_W'($urandom_range(1, 4)) :
                        (pick < 55) ? CFG_W'(0) :
                        (pick < 70) ? CFG_W'(16'hFFFF) : CFG_W'($urandom);
            set_p = $urandom_range(0, 1);
            set_r = $urandom_range(0, 1);
            set_regs(set_p, pairs_word, set_r, rows_word);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 10))
                    load_act(IDX_W'($urandom), ACT_W'($urandom));
            span = span_of(pair_shadow);
            repeat ($urandom_range(1, 6 * span)) push_byte(BYTE_W'($urandom), 1'b1);
        end

        quiesce();
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/i4mv_pkg.sv
rtl/i4mv_ram.sv
rtl/i4mv_ctrl.sv
rtl/i4mv_dpath.sv
rtl/int4_weight_matvec_row_dot.sv
rtl/i4mv_checker.sv
dv/i4mv_dot_check.sv
dv/int4_weight_matvec_row_dot_tb.sv
